>>> design/gcl_pkg.sv
// gcl_pkg: shared types and codes for the glyph coverage lookup block.
// Item payload structs, range record layout, command/format/register codes.
// No dependencies.
package gcl_pkg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  slot;
        logic [15:0] glyph;
        logic [15:0] last_glyph;
        logic [15:0] start_index;
    } gcl_in_t;

    typedef struct packed {
        logic        found;
        logic [16:0] coverage_index;
    } gcl_out_t;

    typedef struct packed {
        logic [15:0] first_glyph;
        logic [15:0] last_glyph;
        logic [15:0] start_index;
    } gcl_range_t;

    localparam logic [1:0] CMD_WR_LIST  = 2'd0;
    localparam logic [1:0] CMD_WR_RANGE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP   = 2'd2;

    localparam logic [1:0] FMT_LIST  = 2'd1;
    localparam logic [1:0] FMT_RANGE = 2'd2;

    localparam logic [1:0] REG_FORMAT      = 2'd0;
    localparam logic [1:0] REG_GLYPH_TOTAL = 2'd1;
    localparam logic [1:0] REG_RANGE_TOTAL = 2'd2;

    localparam int CFG_DATA_W = 11;

endpackage

>>> design/gcl_store.sv
// gcl_store: glyph list memory and range record memory.
// One write port and one registered read port per memory, shared read address.
// Depends on gcl_pkg.
module gcl_store import gcl_pkg::*; #(
    parameter int MAX_GLYPHS = 1024,
    parameter int MAX_RANGES = 256,
    parameter int PW         = 10
) (
    input  logic            aclk,
    input  logic            gl_we,
    input  logic [((MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1)-1:0] gl_waddr,
    input  logic [15:0]     gl_wdata,
    input  logic            rg_we,
    input  logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] rg_waddr,
    input  gcl_range_t      rg_wdata,
    input  logic            rd_en,
    input  logic [PW-1:0]   rd_addr,
    output logic [15:0]     glyph_rd,
    output gcl_range_t      range_rd
);
    localparam int GAW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [15:0] glyph_mem [MAX_GLYPHS];
    gcl_range_t  range_mem [MAX_RANGES];
    logic [15:0] glyph_rd_reg;
    gcl_range_t  range_rd_reg;

    always_ff @(posedge aclk) begin
        if (gl_we) begin
            glyph_mem[gl_waddr] <= gl_wdata;
        end
        if (rd_en) begin
            glyph_rd_reg <= glyph_mem[rd_addr[GAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rg_we) begin
            range_mem[rg_waddr] <= rg_wdata;
        end
        if (rd_en) begin
            range_rd_reg <= range_mem[rd_addr[RAW-1:0]];
        end
    end

    assign glyph_rd = glyph_rd_reg;
    assign range_rd = range_rd_reg;

endmodule

>>> design/gcl_search.sv
// gcl_search: probe sequencer with one shared compare/add unit.
// Runs the power-of-two binary search over the list or range first glyphs.
// Depends on gcl_pkg; reads through gcl_store.
module gcl_search import gcl_pkg::*; #(
    parameter int PW  = 10,
    parameter int CNW = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            use_range,
    input  logic [CNW-1:0]  count,
    input  logic [15:0]     key,
    output logic            rd_en,
    output logic [PW-1:0]   rd_addr,
    input  logic [15:0]     glyph_rd,
    input  gcl_range_t      range_rd,
    output logic            done,
    output gcl_out_t        result
);
    typedef enum logic [2:0] {S_IDLE, S_PROBE, S_CMP, S_FETCH, S_FINAL} state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   addr_reg, addr_next;
    logic [CNW-1:0]  step_reg, step_next;
    logic [15:0]     key_reg, key_next;
    logic            rng_reg, rng_next;

    logic [CNW-1:0]  power;
    logic [CNW-1:0]  extra;
    logic [15:0]     probe_val;
    logic [PW-1:0]   pos_cmp;
    logic [CNW-1:0]  step_half;
    logic [CNW-1:0]  addr_sum;
    logic [15:0]     offs;
    logic [16:0]     range_cov;

    // highest set bit of the entry count
    always_comb begin
        power = '0;
        for (int i = 0; i < CNW; i++) begin
            if (count[i]) begin
                power    = '0;
                power[i] = 1'b1;
            end
        end
    end

    assign extra     = count - power;
    assign probe_val = rng_reg ? range_rd.first_glyph : glyph_rd;
    assign pos_cmp   = (probe_val <= key_reg) ? addr_reg : pos_reg;
    assign step_half = step_reg >> 1;
    assign addr_sum  = CNW'(pos_cmp) + step_half;
    assign offs      = key_reg - range_rd.first_glyph;
    assign range_cov = 17'(range_rd.start_index) + 17'(offs);

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        step_next  = step_reg;
        key_next   = key_reg;
        rng_next   = rng_reg;
        done       = 1'b0;
        result     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    pos_next   = '0;
                    addr_next  = extra[PW-1:0];
                    step_next  = power;
                    key_next   = key;
                    rng_next   = use_range;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                pos_next = pos_cmp;
                if (step_reg > CNW'(1)) begin
                    step_next  = step_half;
                    addr_next  = addr_sum[PW-1:0];
                    state_next = S_PROBE;
                end else begin
                    addr_next  = pos_cmp;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_FINAL;
            end
            S_FINAL: begin
                done = 1'b1;
                if (rng_reg) begin
                    if (range_rd.first_glyph <= key_reg && key_reg <= range_rd.last_glyph) begin
                        result.found          = 1'b1;
                        result.coverage_index = range_cov;
                    end
                end else if (glyph_rd == key_reg) begin
                    result.found          = 1'b1;
                    result.coverage_index = 17'(pos_reg);
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pos_reg  <= pos_next;
        addr_reg <= addr_next;
        step_reg <= step_next;
        key_reg  <= key_next;
        rng_reg  <= rng_next;
    end

    assign rd_en   = (state_reg == S_PROBE) || (state_reg == S_FETCH);
    assign rd_addr = addr_reg;

endmodule

>>> design/glyph_coverage_lookup.sv
// glyph_coverage_lookup: coverage table lookup, glyph list or range records.
// Top level: channel control, config registers, output register.
// Depends on gcl_pkg, gcl_store, gcl_search.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------
//  s_       | in  | s_valid / s_ready    | s_data  (gcl_in_t)
//  m_       | out | m_valid / m_ready    | m_data  (gcl_out_t)
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Write items leave s_ready high. A lookup on a searchable table runs, from
// accept to next accept, through the accept cycle, floor(log2(count))+1 probes
// of one memory read and one compare each, a final fetch and check, and the
// hand-off to the output register. A lookup that cannot hit skips the search
// and goes straight to the hand-off. s_ready is low while a lookup runs.
// The result sits in an output register, so the next item is taken while
// it waits for m_ready. aresetn is synchronous; memories are not cleared.
module glyph_coverage_lookup import gcl_pkg::*; #(
    parameter int MAX_GLYPHS = 1024,
    parameter int MAX_RANGES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gcl_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gcl_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int GAW  = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int RAW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int MAXD = (MAX_GLYPHS > MAX_RANGES) ? MAX_GLYPHS : MAX_RANGES;
    localparam int PW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int CNW  = PW + 1;

    typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_RESP} tstate_t;

    tstate_t      state_reg, state_next;
    logic [1:0]   format_reg;
    logic [10:0]  glyph_total_reg;
    logic [8:0]   range_total_reg;
    gcl_out_t     resp_reg, resp_next;
    logic         m_valid_reg, m_valid_next;
    gcl_out_t     m_data_reg, m_data_next;

    logic         s_fire;
    logic [CNW-1:0] n_glyph, n_range, n_sel;
    logic         searchable;
    logic         srch_start;
    logic         rd_en;
    logic [PW-1:0] rd_addr;
    logic [15:0]  glyph_rd;
    gcl_range_t   range_rd;
    logic         srch_done;
    gcl_out_t     srch_result;
    gcl_range_t   rg_wdata;

    assign s_ready   = (state_reg == T_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // counts saturate at the store depth
    assign n_glyph = (32'(glyph_total_reg) > MAX_GLYPHS) ? CNW'(MAX_GLYPHS)
                                                         : CNW'(glyph_total_reg);
    assign n_range = (32'(range_total_reg) > MAX_RANGES) ? CNW'(MAX_RANGES)
                                                         : CNW'(range_total_reg);
    assign n_sel   = (format_reg == FMT_RANGE) ? n_range : n_glyph;
    assign searchable = ((format_reg == FMT_LIST) || (format_reg == FMT_RANGE))
                        && (n_sel != '0);

    assign srch_start = s_fire && (s_data.cmd == CMD_LOOKUP) && searchable;

    assign rg_wdata.first_glyph = s_data.glyph;
    assign rg_wdata.last_glyph  = s_data.last_glyph;
    assign rg_wdata.start_index = s_data.start_index;

    gcl_store #(
        .MAX_GLYPHS(MAX_GLYPHS),
        .MAX_RANGES(MAX_RANGES),
        .PW        (PW)
    ) u_store (
        .aclk    (aclk),
        .gl_we   (s_fire && (s_data.cmd == CMD_WR_LIST) && (32'(s_data.slot) < MAX_GLYPHS)),
        .gl_waddr(GAW'(s_data.slot)),
        .gl_wdata(s_data.glyph),
        .rg_we   (s_fire && (s_data.cmd == CMD_WR_RANGE) && (32'(s_data.slot) < MAX_RANGES)),
        .rg_waddr(RAW'(s_data.slot)),
        .rg_wdata(rg_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .glyph_rd(glyph_rd),
        .range_rd(range_rd)
    );

    gcl_search #(
        .PW (PW),
        .CNW(CNW)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (srch_start),
        .use_range(format_reg == FMT_RANGE),
        .count    (n_sel),
        .key      (s_data.glyph),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .glyph_rd (glyph_rd),
        .range_rd (range_rd),
        .done     (srch_done),
        .result   (srch_result)
    );

    always_comb begin
        state_next   = state_reg;
        resp_next    = resp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE: begin
                if (s_fire && (s_data.cmd == CMD_LOOKUP)) begin
                    if (searchable) begin
                        state_next = T_SEARCH;
                    end else begin
                        resp_next  = '0;
                        state_next = T_RESP;
                    end
                end
            end
            T_SEARCH: begin
                if (srch_done) begin
                    resp_next  = srch_result;
                    state_next = T_RESP;
                end
            end
            T_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = resp_reg;
                    state_next   = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= T_IDLE;
            m_valid_reg     <= 1'b0;
            format_reg      <= '0;
            glyph_total_reg <= '0;
            range_total_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_FORMAT:      format_reg      <= cfg_data[1:0];
                    REG_GLYPH_TOTAL: glyph_total_reg <= cfg_data[10:0];
                    REG_RANGE_TOTAL: range_total_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
        resp_reg   <= resp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> verif/gcl_scoreboard_pkg.sv
`timescale 1ns / 100ps
// gcl_scoreboard_pkg: coverage lookup predictor and result scoreboard used by
// tb_glyph_coverage_lookup. Depends on gcl_pkg for the item types and codes.
package gcl_scoreboard_pkg;
    import gcl_pkg::*;

    localparam int GLYPH_DEPTH = 1024;
    localparam int RANGE_DEPTH = 256;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] FMT_NONE   = 2'd0;
    localparam logic [1:0] FMT_SPARE  = 2'd3;

    class coverage_scoreboard;
        logic [1:0]  table_fmt = FMT_NONE;
        int unsigned glyph_cnt = 0;
        int unsigned range_cnt = 0;
        bit [15:0]   glyph_list [GLYPH_DEPTH];
        bit [15:0]   range_first [RANGE_DEPTH];
        bit [15:0]   range_last [RANGE_DEPTH];
        bit [15:0]   range_start [RANGE_DEPTH];
        gcl_out_t    lookup_q[$];
        int unsigned error_count = 0;
        int unsigned result_count = 0;

        function void set_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FORMAT:      table_fmt = value[1:0];
                REG_GLYPH_TOTAL: glyph_cnt = 32'(value);
                REG_RANGE_TOTAL: range_cnt = 32'(value[8:0]);
                default: ;
            endcase
        endfunction

        function int unsigned key_at(input bit ranges, input int unsigned idx);
            return ranges ? 32'(range_first[idx]) : 32'(glyph_list[idx]);
        endfunction

        // last entry not above key; first probe at count minus top power of two
        function int unsigned floor_slot(input bit ranges, input int unsigned count,
                                         input int unsigned key);
            int unsigned power;
            int unsigned extra;
            int unsigned pos;
            int unsigned step;
            power = 1;
            while (power <= (count >> 1))
                power = power << 1;
            extra = count - power;
            pos = 0;
            if (key_at(ranges, extra) <= key)
                pos = extra;
            step = power;
            while (step > 1) begin
                step = step >> 1;
                if (key_at(ranges, pos + step) <= key)
                    pos = pos + step;
            end
            return pos;
        endfunction

        function gcl_out_t predict_lookup(input bit [15:0] glyph);
            gcl_out_t    res;
            int unsigned n;
            int unsigned pos;
            int unsigned first;
            int unsigned key;
            res = '0;
            key = 32'(glyph);
            if (table_fmt == FMT_LIST) begin
                n = (glyph_cnt > GLYPH_DEPTH) ? GLYPH_DEPTH : glyph_cnt;
                if (n != 0) begin
                    pos = floor_slot(1'b0, n, key);
                    if (glyph_list[pos] == glyph) begin
                        res.found = 1'b1;
                        res.coverage_index = 17'(pos);
                    end
                end
            end else if (table_fmt == FMT_RANGE) begin
                n = (range_cnt > RANGE_DEPTH) ? RANGE_DEPTH : range_cnt;
                if (n != 0) begin
                    pos = floor_slot(1'b1, n, key);
                    first = 32'(range_first[pos]);
                    if (first <= key && key <= 32'(range_last[pos])) begin
                        res.found = 1'b1;
                        res.coverage_index = 17'(32'(range_start[pos]) + (key - first));
                    end
                end
            end
            return res;
        endfunction

        function void note_item(input gcl_in_t item);
            case (item.cmd)
                CMD_WR_LIST: glyph_list[item.slot] = item.glyph;
                CMD_WR_RANGE: begin
                    // slots past the record store are dropped
                    if (32'(item.slot) < RANGE_DEPTH) begin
                        range_first[item.slot] = item.glyph;
                        range_last[item.slot]  = item.last_glyph;
                        range_start[item.slot] = item.start_index;
                    end
                end
                CMD_LOOKUP: lookup_q.push_back(predict_lookup(item.glyph));
                default: ;
            endcase
        endfunction

        task report_mismatch(input string what);
            error_count++;
            $display("[%0t] result %0d mismatch: %s", $time, result_count, what);
        endtask

        task check_result(input gcl_out_t got);
            gcl_out_t want;
            result_count++;
            if (lookup_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b index=%0d",
                                          got.found, got.coverage_index));
            end else begin
                want = lookup_q.pop_front();
                if (got.found !== want.found)
                    report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
                if (got.coverage_index !== want.coverage_index)
                    report_mismatch($sformatf("coverage_index %0d, want %0d",
                                              got.coverage_index, want.coverage_index));
            end
        endtask
    endclass

endpackage

>>> verif/tb_glyph_coverage_lookup.sv
`timescale 1ns / 100ps
// tb_glyph_coverage_lookup: directed and random regression of the coverage
// lookup block. Depends on gcl_pkg, gcl_scoreboard_pkg and glyph_coverage_lookup.
module tb_glyph_coverage_lookup;
    import gcl_pkg::*;
    import gcl_scoreboard_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 38;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    gcl_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    gcl_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = REG_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned sender_idle_pct = 23;
    int unsigned recv_stall_pct = 74;
    logic        hold_req = 1'b0;
    int unsigned cycle_count = 0;

    coverage_scoreboard sb;

    glyph_coverage_lookup i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("glyph_coverage_lookup regression: fail");
        $finish;
    end

    // result side; one long hold-off when asked, so the block backs up
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    task automatic send_item(input gcl_in_t item);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(item);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.set_register(idx, value[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, wait for every pending result, then let writes settle
    task automatic drain(input int unsigned settle);
        s_valid <= 1'b0;
        while (sb.lookup_q.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] fmt, input int unsigned glyphs,
                             input int unsigned ranges);
        drain(SETTLE_CYCLES);
        write_reg(REG_FORMAT, 32'(fmt));
        write_reg(REG_GLYPH_TOTAL, glyphs);
        write_reg(REG_RANGE_TOTAL, ranges);
    endtask

    // random fill for the fields an item does not use
    function automatic gcl_in_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(gcl_in_t)-1:0];
    endfunction

    function automatic gcl_in_t lookup_item(input logic [15:0] glyph);
        gcl_in_t item;
        item = noise_item();
        item.cmd = CMD_LOOKUP;
        item.glyph = glyph;
        return item;
    endfunction

    function automatic gcl_in_t list_item(input int unsigned slot, input logic [15:0] glyph);
        gcl_in_t item;
        item = noise_item();
        item.cmd = CMD_WR_LIST;
        item.slot = 10'(slot);
        item.glyph = glyph;
        return item;
    endfunction

    function automatic gcl_in_t range_item(input int unsigned slot, input logic [15:0] first,
                                           input logic [15:0] last, input logic [15:0] start);
        gcl_in_t item;
        item = noise_item();
        item.cmd = CMD_WR_RANGE;
        item.slot = 10'(slot);
        item.glyph = first;
        item.last_glyph = last;
        item.start_index = start;
        return item;
    endfunction

    // mostly stored glyphs and their neighbors, the rest anywhere
    function automatic logic [15:0] lookup_glyph();
        int unsigned n;
        int unsigned i;
        int unsigned pick;
        logic [15:0] g;
        pick = $urandom_range(0, 99);
        g = 16'($urandom);
        if (sb.table_fmt == FMT_LIST && sb.glyph_cnt != 0) begin
            n = (sb.glyph_cnt > GLYPH_DEPTH) ? GLYPH_DEPTH : sb.glyph_cnt;
            i = $urandom_range(0, n - 1);
            if (pick < 60)
                g = sb.glyph_list[i];
            else if (pick < 80)
                g = pick[0] ? sb.glyph_list[i] + 16'd1 : sb.glyph_list[i] - 16'd1;
        end else if (sb.table_fmt == FMT_RANGE && sb.range_cnt != 0) begin
            n = (sb.range_cnt > RANGE_DEPTH) ? RANGE_DEPTH : sb.range_cnt;
            i = $urandom_range(0, n - 1);
            if (pick < 60)
                g = 16'($urandom_range(32'(sb.range_first[i]), 32'(sb.range_last[i])));
            else if (pick < 80)
                g = pick[0] ? sb.range_last[i] + 16'd1 : sb.range_first[i] - 16'd1;
        end
        return g;
    endfunction

    function automatic gcl_in_t random_item();
        gcl_in_t     item;
        int unsigned pick;
        int unsigned s;
        int unsigned lo;
        int unsigned hi;
        pick = $urandom_range(0, 99);
        item = noise_item();
        if (pick < 78) begin
            item.cmd = CMD_LOOKUP;
            item.glyph = lookup_glyph();
        end else if (pick < 88) begin
            item.cmd = CMD_WR_LIST;
            s = 32'(item.slot);
            // most rewrites keep the list sorted
            if ($urandom_range(0, 9) < 7) begin
                lo = (s > 0) ? 32'(sb.glyph_list[s - 1]) : 0;
                hi = (s < GLYPH_DEPTH - 1) ? 32'(sb.glyph_list[s + 1]) : 32'hFFFF;
                item.glyph = 16'($urandom_range(lo, hi));
            end
        end else if (pick < 96) begin
            item.cmd = CMD_WR_RANGE;
            if ($urandom_range(0, 9) < 7) begin
                s = $urandom_range(0, RANGE_DEPTH - 1);
                item.slot = 10'(s);
                lo = (s > 0) ? 32'(sb.range_last[s - 1]) : 0;
                hi = (s < RANGE_DEPTH - 1) ? 32'(sb.range_first[s + 1]) : 32'hFFFF;
                item.glyph = 16'($urandom_range(lo, hi));
                item.last_glyph = 16'($urandom_range(32'(item.glyph), hi));
            end
        end else begin
            item.cmd = CMD_UNUSED;
        end
        return item;
    endfunction

    task automatic run_phase(input logic [1:0] fmt, input int unsigned glyphs,
                             input int unsigned ranges, input bit hold, input bit pause);
        configure(fmt, glyphs, ranges);
        if (hold)
            hold_req <= 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (pause && k == PHASE_ITEMS / 2)
                drain(1);
            send_item(random_item());
        end
    endtask

    initial begin : stimulus
        int unsigned g;
        int unsigned hi;
        gcl_in_t     noise;
        sb = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: no format, empty tables
        send_item(lookup_item(16'h0000));
        send_item(lookup_item(16'hFFFF));
        noise = '1;
        send_item(noise);
        configure(FMT_SPARE, 0, 0);
        send_item(lookup_item(16'h1234));
        configure(FMT_LIST, 0, 0);
        send_item(lookup_item(16'h0000));
        configure(FMT_RANGE, 0, 0);
        send_item(lookup_item(16'hFFFF));

        // fill both stores with sorted data, ends at glyph 0 and 0xFFFF
        g = 0;
        for (int k = 0; k < GLYPH_DEPTH; k++) begin
            send_item(list_item(k, (k == GLYPH_DEPTH - 1) ? 16'hFFFF : 16'(g)));
            g = g + $urandom_range(1, 60);
        end
        g = 0;
        for (int k = 0; k < RANGE_DEPTH; k++) begin
            hi = (k == RANGE_DEPTH - 1) ? 32'hFFFF : g + $urandom_range(0, 150);
            send_item(range_item(k, 16'(g), 16'(hi), (k == 0) ? 16'h0000 :
                                 (k == RANGE_DEPTH - 1) ? 16'hFFFF : 16'($urandom)));
            g = hi + $urandom_range(1, 100);
        end
        send_item(range_item(RANGE_DEPTH, 16'h0000, 16'hFFFF, 16'h5555));
        send_item(range_item(GLYPH_DEPTH - 1, 16'h0000, 16'hFFFF, 16'hAAAA));

        configure(FMT_LIST, GLYPH_DEPTH, 0);
        send_item(lookup_item(16'h0000));
        send_item(lookup_item(16'hFFFF));
        send_item(lookup_item(sb.glyph_list[300]));
        send_item(lookup_item(sb.glyph_list[300] + 16'd1));
        configure(FMT_RANGE, 0, RANGE_DEPTH);
        send_item(lookup_item(16'h0000));
        send_item(lookup_item(16'hFFFF));
        send_item(lookup_item(sb.range_last[10] + 16'd1));
        send_item(lookup_item(sb.range_first[100]));

        run_phase(FMT_LIST, 1, 0, 1'b0, 1'b0);
        run_phase(FMT_LIST, GLYPH_DEPTH, 0, 1'b0, 1'b0);
        run_phase(FMT_LIST, 2047, 511, 1'b1, 1'b0);
        run_phase(FMT_LIST, $urandom_range(2, 1000), 0, 1'b0, 1'b0);

        sender_idle_pct = 74;
        recv_stall_pct = 23;
        run_phase(FMT_RANGE, 0, 1, 1'b0, 1'b0);
        run_phase(FMT_RANGE, 0, RANGE_DEPTH, 1'b0, 1'b1);
        run_phase(FMT_RANGE, 2047, 511, 1'b0, 1'b0);
        run_phase(FMT_RANGE, 0, $urandom_range(2, 255), 1'b0, 1'b0);

        sender_idle_pct = 0;
        recv_stall_pct = 0;
        run_phase(FMT_NONE, GLYPH_DEPTH, RANGE_DEPTH, 1'b0, 1'b0);
        run_phase(FMT_SPARE, GLYPH_DEPTH, RANGE_DEPTH, 1'b0, 1'b0);
        run_phase(FMT_LIST, $urandom_range(2, 16), 0, 1'b0, 1'b0);
        run_phase(FMT_RANGE, 0, $urandom_range(2, 8), 1'b0, 1'b0);

        drain(SETTLE_CYCLES);
        if (sb.error_count == 0)
            $display("glyph_coverage_lookup regression: pass");
        else
            $display("glyph_coverage_lookup regression: fail");
        $finish;
    end

endmodule
